// ----- hw/rtl/sha_pkg.sv -----
// Package: SHA-256 constants, types and round functions.
package sha_pkg;

   localparam int WordWidth  = 32;
   localparam int BlockWords = 16;
   localparam int HashWords  = 8;
   localparam int Rounds     = 64;

   typedef logic [WordWidth-1:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_UPDATE,
      ST_OUTPUT
   } state_type;

   // Control from the sequencer to the round unit.
   typedef struct packed {
      logic start;   // load working vars from hash
      logic step;    // run one round
      logic update;  // fold working vars into hash
      logic init;    // return hash to initial values
   } core_ctrl_type;

   function automatic word_type initial_hash(input logic [2:0] idx);
      unique case (idx)
         3'd0: initial_hash = 32'h6a09e667;
         3'd1: initial_hash = 32'hbb67ae85;
         3'd2: initial_hash = 32'h3c6ef372;
         3'd3: initial_hash = 32'ha54ff53a;
         3'd4: initial_hash = 32'h510e527f;
         3'd5: initial_hash = 32'h9b05688c;
         3'd6: initial_hash = 32'h1f83d9ab;
         default: initial_hash = 32'h5be0cd19;
      endcase
   endfunction

   localparam word_type RoundK [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (WordWidth - n));
   endfunction

endpackage

// ----- hw/rtl/sha_if.sv -----
// Interfaces: request and response channels.
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;
   modport source (output valid, data_byte, byte_present, end_of_message, input ready);
   modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  word_index;
   logic [31:0] digest_word;
   logic        last_word;
   modport source (output valid, word_index, digest_word, last_word, input ready);
   modport sink   (input valid, word_index, digest_word, last_word, output ready);
endinterface

// ----- hw/rtl/sha256_message_digest.sv -----
// Top level: SHA-256 digest of a byte stream, one byte per item.
//
//  port | dir | fields                                     | handshake
//  req  | in  | data_byte[8], byte_present, end_of_message | valid/ready
//  rsp  | out | word_index[3], digest_word[32], last_word  | valid/ready
//
// A byte that does not complete a block keeps req.ready high; such items can follow back to back.
// A byte that completes a block holds req.ready low through load, 64 rounds and update.
// An end item adds, per padded block, a padding step, load, 64 rounds and update: one block
// when fewer than 56 bytes are pending, two otherwise. Eight words then follow, one
// per cycle with rsp.ready high; a stall on rsp holds the current word.
// Reset is synchronous, active high; the initial hash loads while it is asserted.
module sha256_message_digest
   import sha_pkg::*;
(
   input  logic clock,
   input  logic reset,
   sha_req_if.sink   req,
   sha_rsp_if.source rsp
);

   state_type     state_ff, state_in;
   core_ctrl_type ctrl;
   word_type      blk_ff [BlockWords];
   word_type      blk_in [BlockWords];
   logic [31:0]   len_ff;
   logic [5:0]    round_ff;
   logic [2:0]    out_ff;
   logic          pad_ff;      // end came with a full block; padding still to build
   logic          second_ff;   // a length-only block still follows
   logic          final_ff;    // last padded block built; digest follows
   logic          accept;
   logic          full;
   logic [5:0]    fill;
   logic [31:0]   bit_len;
   word_type      hash_word;

   assign accept  = req.valid && req.ready;
   assign fill    = len_ff[5:0];
   // This item completes a 64-byte block.
   assign full    = accept && req.byte_present && (fill == 6'd63);
   // Lower 32 bits of the bit length; the byte count wraps on its own.
   assign bit_len = {len_ff[28:0], 3'b000};

   sha_core u_core (
      .clock       (clock),
      .ctrl        (ctrl),
      .round_idx   (round_ff),
      .block_words (blk_ff),
      .read_idx    (out_ff),
      .hash_word   (hash_word)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (full) state_in = ST_LOAD;
            else if (accept && req.end_of_message) state_in = ST_PAD;
         end
         ST_PAD:    state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_ROUND;
         ST_ROUND:  if (round_ff == 6'd63) state_in = ST_UPDATE;
         ST_UPDATE: begin
            // Build another padded block, show the digest, or wait for bytes.
            priority if (pad_ff || second_ff) state_in = ST_PAD;
            else if (final_ff) state_in = ST_OUTPUT;
            else state_in = ST_IDLE;
         end
         ST_OUTPUT: if (rsp.ready && out_ff == 3'd7) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      ctrl        = '0;
      ctrl.start  = (state_ff == ST_LOAD);
      ctrl.step   = (state_ff == ST_ROUND);
      ctrl.update = (state_ff == ST_UPDATE);
      ctrl.init   = reset || (state_ff == ST_OUTPUT && rsp.ready && out_ff == 3'd7);
      req.ready   = (state_ff == ST_IDLE) && !reset;
      rsp.valid   = (state_ff == ST_OUTPUT);
   end

   assign rsp.word_index  = out_ff;
   assign rsp.digest_word = hash_word;
   assign rsp.last_word   = (out_ff == 3'd7);

   // Block buffer: take bytes in idle, write padding in ST_PAD.
   always_comb begin
      blk_in = blk_ff;
      if (state_ff == ST_IDLE && accept && req.byte_present) begin
         // First byte of each group of four lands in the top lane.
         blk_in[fill[5:2]][{~fill[1:0], 3'b000} +: 8] = req.data_byte;
      end else if (state_ff == ST_PAD) begin
         if (second_ff) begin
            // Length-only block after a pad that overflowed the first one.
            for (int j = 0; j < BlockWords; j++) blk_in[j] = '0;
            blk_in[BlockWords-1] = bit_len;
         end else begin
            // Marker byte at the fill point, zeros after it.
            for (int j = 0; j < BlockWords; j++) begin
               for (int b = 0; b < 4; b++) begin
                  if (6'(4*j + b) == fill) blk_in[j][31-8*b -: 8] = 8'h80;
                  else if (6'(4*j + b) > fill) blk_in[j][31-8*b -: 8] = 8'h00;
               end
            end
            // Room left for the length: fold it in here.
            if (fill < 6'd56) blk_in[BlockWords-1] = bit_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         len_ff    <= '0;
         round_ff  <= '0;
         out_ff    <= '0;
         pad_ff    <= 1'b0;
         second_ff <= 1'b0;
         final_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req.byte_present) len_ff <= len_ff + 32'd1;
               // Hold the end mark across the compression of a full block.
               if (full) pad_ff <= req.end_of_message;
            end
            ST_PAD: begin
               pad_ff <= 1'b0;
               if (second_ff) begin
                  second_ff <= 1'b0;
                  final_ff  <= 1'b1;
               end else if (fill >= 6'd56) begin
                  second_ff <= 1'b1;
               end else begin
                  final_ff <= 1'b1;
               end
            end
            ST_LOAD:  round_ff <= '0;
            ST_ROUND: round_ff <= round_ff + 6'd1;
            ST_OUTPUT: begin
               if (rsp.ready) begin
                  out_ff <= out_ff + 3'd1;
                  // Last word taken: drop the count, hash returns to initial values.
                  if (out_ff == 3'd7) begin
                     len_ff   <= '0;
                     final_ff <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// ----- hw/rtl/sha_core.sv -----
// Round unit: schedule window, working variables and running hash.
module sha_core
   import sha_pkg::*;
(
   input  logic          clock,
   input  core_ctrl_type ctrl,
   input  logic [5:0]    round_idx,
   input  word_type      block_words [BlockWords],
   input  logic [2:0]    read_idx,
   output word_type      hash_word
);

   word_type hash_ff [HashWords];
   word_type hash_in [HashWords];
   word_type vars_ff [HashWords];
   word_type vars_in [HashWords];
   word_type win_ff  [BlockWords];
   word_type win_in  [BlockWords];

   word_type w, s0, s1, w2, w7, w15, w16, t1, t2;

   always_comb begin
      w2  = win_ff[4'(round_idx - 6'd2)];
      w7  = win_ff[4'(round_idx - 6'd7)];
      w15 = win_ff[4'(round_idx - 6'd15)];
      w16 = win_ff[round_idx[3:0]];
      s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
      s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
      w   = (round_idx < 6'd16) ? w16 : (s1 + w7 + s0 + w16);
      t1  = vars_ff[7] + (rotr(vars_ff[4], 6) ^ rotr(vars_ff[4], 11) ^ rotr(vars_ff[4], 25))
            + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
            + RoundK[round_idx] + w;
      t2  = (rotr(vars_ff[0], 2) ^ rotr(vars_ff[0], 13) ^ rotr(vars_ff[0], 22))
            + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
               ^ (vars_ff[1] & vars_ff[2]));

      hash_in = hash_ff;
      vars_in = vars_ff;
      win_in  = win_ff;
      if (ctrl.start) begin
         vars_in = hash_ff;
         win_in  = block_words;
      end else if (ctrl.step) begin
         win_in[round_idx[3:0]] = w;
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
      end
      if (ctrl.init) begin
         for (int i = 0; i < HashWords; i++) hash_in[i] = initial_hash(3'(i));
      end else if (ctrl.update) begin
         for (int i = 0; i < HashWords; i++) hash_in[i] = hash_ff[i] + vars_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      vars_ff <= vars_in;
      win_ff  <= win_in;
   end

   assign hash_word = hash_ff[read_idx];

endmodule

// ----- hw/rtl/sha_checker.sv -----
// Checker: port-level properties of the digest block, bound to the top level.
module sha_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_word_index,
   input logic [31:0] rsp_digest_word,
   input logic        rsp_last_word
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken during output");

   a_no_early_digest: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("digest right after request");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last_word mismatch");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word)
      && $stable(rsp_word_index)) else $error("stalled word changed");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=> rsp_valid
      && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("word index skipped");

endmodule

bind sha256_message_digest sha_checker u_sha_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_word_index  (rsp.word_index),
   .rsp_digest_word (rsp.digest_word),
   .rsp_last_word   (rsp.last_word)
);
